>>> sv/assert_macros.svh
// Assertion macros used by the RTL in serial_line_assembler.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sla_pkg.sv
// Constants for the serial line assembler.
package sla_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [7:0] KEY_BACKSPACE = 8'd127;
	localparam logic [7:0] KEY_CR        = 8'd13;
	localparam logic [7:0] KEY_LF        = 8'd10;

endpackage

>>> sv/serial_line_assembler.sv
// Serial line assembler: builds a command line from received bytes and plays it back.
// Received bytes arrive one transaction at a time on the s_ stream. An ordinary byte,
// a backspace or an LF on an empty line is absorbed with no output. A CR or LF on
// a non-empty line of n bytes replays the line from the line store on the m_ stream,
// then a newline marked tlast; the store has one registered read port, so each stored
// byte passes through a fetch state and then a send state (address, then send). The input
// is not ready during a replay. A CR on an empty line gives one transaction with tuser
// set (empty-line notice, tdata zero, tlast set). A line that grows to LINE_DEPTH bytes
// is dropped without notice. There is no clearing pass after reset.
`include "assert_macros.svh"

module serial_line_assembler #(
	parameter int LINE_DEPTH = sla_pkg::LINE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [0:0] m_tuser,   // [0] out_empty
	output logic       m_tlast
);

	localparam int CW = $clog2(LINE_DEPTH);
	localparam logic [CW:0] DEPTH_V = (CW+1)'(LINE_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_SEND  = 3'd2;
	localparam logic [2:0] S_NL    = 3'd3;
	localparam logic [2:0] S_EMPTY = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    line_store_q [LINE_DEPTH];

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_empty_q;
	logic          out_last_q;

	logic          in_xfer;
	logic          out_free;
	logic          out_load;
	logic          is_term;
	logic          do_append;
	logic [CW:0]   cnt_inc;
	logic [CW:0]   idx_inc;

	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = out_free
		&& (state_q == S_SEND || state_q == S_NL || state_q == S_EMPTY);
	assign is_term   = (s_tdata == sla_pkg::KEY_CR) || (s_tdata == sla_pkg::KEY_LF);
	assign do_append = in_xfer && !is_term && (s_tdata != sla_pkg::KEY_BACKSPACE);
	assign cnt_inc   = {1'b0, count_q} + 1'b1;
	assign idx_inc   = {1'b0, rd_idx_q} + 1'b1;

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_byte_q;
	assign m_tuser[0] = out_empty_q;
	assign m_tlast    = out_last_q;

	// line store: one write port (append), one registered read port (replay)
	always_ff @(posedge clk) begin
		if (do_append) begin
			line_store_q[count_q] <= s_tdata;
		end
		rd_data_q <= line_store_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (is_term) begin
							rd_idx_q <= '0;
							if (count_q != '0) begin
								state_q <= S_FETCH;
							end else if (s_tdata == sla_pkg::KEY_CR) begin
								state_q <= S_EMPTY;
							end
						end else if (s_tdata == sla_pkg::KEY_BACKSPACE) begin
							if (count_q != '0) begin
								count_q <= count_q - 1'b1;
							end
						end else begin
							// overflow drops the whole line
							count_q <= (cnt_inc == DEPTH_V) ? '0 : cnt_inc[CW-1:0];
						end
					end
				end
				S_FETCH: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_free) begin
						if (idx_inc == {1'b0, count_q}) begin
							state_q <= S_NL;
						end else begin
							rd_idx_q <= idx_inc[CW-1:0];
							state_q  <= S_FETCH;
						end
					end
				end
				S_NL: begin
					if (out_free) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload, loaded whenever a result leaves the sequencer
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				S_SEND: begin
					out_byte_q  <= rd_data_q;
					out_empty_q <= 1'b0;
					out_last_q  <= 1'b0;
				end
				S_NL: begin
					out_byte_q  <= sla_pkg::KEY_LF;
					out_empty_q <= 1'b0;
					out_last_q  <= 1'b1;
				end
				S_EMPTY: begin
					out_byte_q  <= '0;
					out_empty_q <= 1'b1;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_byte_q  <= out_byte_q;
					out_empty_q <= out_empty_q;
					out_last_q  <= out_last_q;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_count_range, 1'b1, {1'b0, count_q} < DEPTH_V, "line count reached depth")
	`ASSERT_IMPLY(a_idx_in_line, state_q == S_SEND || state_q == S_FETCH, rd_idx_q < count_q,
		"replay index beyond stored line")
	`ASSERT_NEXT(a_nl_clears, state_q == S_NL && out_free,
		count_q == '0 && state_q == S_IDLE && m_tvalid && m_tlast, "newline did not end the line")
	`ASSERT_IMPLY(a_notice_form, m_tvalid && m_tuser[0], m_tlast && m_tdata == '0,
		"malformed empty-line notice")

endmodule
